// ===== sv/tgss_pkg.sv =====
// Shared types and codes for the toroidal grid spread step block.
package tgss_pkg;

   // Configuration registers
   localparam int CSR_W = 7;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_USED = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_USED = 1'd1;
   localparam logic [CSR_W-1:0] CSR_SIZE_RESET = 7'd64;

   // Request operation codes
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_STEP = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // Grid address select
   localparam logic [2:0] ASEL_CENTER = 3'd0;
   localparam logic [2:0] ASEL_UP     = 3'd1;
   localparam logic [2:0] ASEL_DOWN   = 3'd2;
   localparam logic [2:0] ASEL_LEFT   = 3'd3;
   localparam logic [2:0] ASEL_RIGHT  = 3'd4;

   // Write data select
   localparam logic [1:0] WSEL_VALUE = 2'd0;
   localparam logic [1:0] WSEL_RDATA = 2'd1;
   localparam logic [1:0] WSEL_LABEL = 2'd2;

   // Response data select
   localparam logic [1:0] RSEL_ZERO  = 2'd0;
   localparam logic [1:0] RSEL_RDATA = 2'd1;
   localparam logic [1:0] RSEL_LABEL = 2'd2;

   typedef struct packed {
      logic [1:0] operation;
      logic [5:0] row;
      logic [5:0] col;
      logic [7:0] value;
   } tgss_req_type;

   typedef struct packed {
      logic [7:0] cell_value;
      logic       coord_error;
   } tgss_rsp_type;

   typedef struct packed {
      logic       req_capture;
      logic       ram_en;
      logic       ram_we;
      logic [2:0] addr_sel;
      logic [1:0] wdata_sel;
      logic       label_capture;
      logic       rsp_load;
      logic [1:0] rsp_sel;
   } tgss_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       coord_err;
   } tgss_stat_type;

endpackage

// ===== sv/tgss_ram.sv =====
// Generic single-port RAM with registered read.
module tgss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             en,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/tgss_datapath.sv =====
// Datapath: size registers, request hold, neighbor addressing, grid RAM, response register.
module tgss_datapath #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64,
   parameter int LABEL_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [tgss_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tgss_pkg::CSR_W-1:0]         csr_wdata,
   input  tgss_pkg::tgss_req_type             req_data,
   input  tgss_pkg::tgss_cmd_type             cmd,
   output tgss_pkg::tgss_stat_type            stat,
   output tgss_pkg::tgss_rsp_type             rsp_data
);
   import tgss_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW = $clog2(DEPTH);
   localparam int RowLim = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
   localparam int ColLim = (MAX_COLS > 127) ? 127 : MAX_COLS;

   logic [CSR_W-1:0]      rows_used_ff;
   logic [CSR_W-1:0]      cols_used_ff;
   tgss_req_type          req_ff;
   logic [LABEL_BITS-1:0] label_ff;
   tgss_rsp_type          rsp_ff;

   logic [CSR_W-1:0]      nr, nc, r, c;
   logic [CSR_W-1:0]      r_dec, r_inc, c_dec, c_inc;
   logic                  op_known, out_of_grid;
   logic [AW-1:0]         ram_addr;
   logic [LABEL_BITS-1:0] ram_wdata, ram_rdata;
   tgss_rsp_type          rsp_in;

   function automatic logic [AW-1:0] cell_addr(input logic [CSR_W-1:0] rr,
                                               input logic [CSR_W-1:0] cc);
      return AW'(rr) * AW'(MAX_COLS) + AW'(cc);
   endfunction

   // Size registers; the sizes in use are saturated to the array dimensions
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_used_ff <= CSR_SIZE_RESET;
         cols_used_ff <= CSR_SIZE_RESET;
      end else if (csr_write_en) begin
         if (csr_index == CSR_ROWS_USED) begin
            rows_used_ff <= csr_wdata;
         end
         if (csr_index == CSR_COLS_USED) begin
            cols_used_ff <= csr_wdata;
         end
      end
   end

   assign nr = (rows_used_ff > CSR_W'(RowLim)) ? CSR_W'(RowLim) : rows_used_ff;
   assign nc = (cols_used_ff > CSR_W'(ColLim)) ? CSR_W'(ColLim) : cols_used_ff;

   always_ff @(posedge clock) begin
      if (cmd.req_capture) begin
         req_ff <= req_data;
      end
   end

   assign r = {1'b0, req_ff.row};
   assign c = {1'b0, req_ff.col};

   assign op_known    = (req_ff.operation inside {OP_LOAD, OP_STEP, OP_READ});
   assign out_of_grid = (r >= nr) || (c >= nc);
   assign stat.op        = req_ff.operation;
   assign stat.coord_err = op_known && out_of_grid;

   // Torus neighbors
   assign r_dec = (r == '0) ? nr - 1'b1 : r - 1'b1;
   assign r_inc = (r + 1'b1 >= nr) ? '0 : r + 1'b1;
   assign c_dec = (c == '0) ? nc - 1'b1 : c - 1'b1;
   assign c_inc = (c + 1'b1 >= nc) ? '0 : c + 1'b1;

   always_comb begin
      case (cmd.addr_sel)
         ASEL_UP:    ram_addr = cell_addr(r_dec, c);
         ASEL_DOWN:  ram_addr = cell_addr(r_inc, c);
         ASEL_LEFT:  ram_addr = cell_addr(r, c_dec);
         ASEL_RIGHT: ram_addr = cell_addr(r, c_inc);
         default:    ram_addr = cell_addr(r, c);
      endcase
   end

   always_comb begin
      case (cmd.wdata_sel)
         WSEL_RDATA: ram_wdata = ram_rdata;
         WSEL_LABEL: ram_wdata = label_ff;
         default:    ram_wdata = LABEL_BITS'(req_ff.value);
      endcase
   end

   tgss_ram #(
      .WIDTH (LABEL_BITS),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock (clock),
      .en    (cmd.ram_en),
      .we    (cmd.ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.label_capture) begin
         label_ff <= ram_rdata;
      end
   end

   always_comb begin
      rsp_in.coord_error = stat.coord_err;
      case (cmd.rsp_sel)
         RSEL_RDATA: rsp_in.cell_value = 8'(ram_rdata);
         RSEL_LABEL: rsp_in.cell_value = 8'(label_ff);
         default:    rsp_in.cell_value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== sv/tgss_ctrl.sv =====
// Controller: sequences grid accesses per request and owns the handshakes.
module tgss_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  tgss_pkg::tgss_stat_type stat,
   output tgss_pkg::tgss_cmd_type  cmd
);
   import tgss_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ISSUE = 3'd1;
   localparam logic [2:0] S_CAP   = 3'd2;
   localparam logic [2:0] S_W1    = 3'd3;
   localparam logic [2:0] S_W2    = 3'd4;
   localparam logic [2:0] S_W3    = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // no request is taken while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.req_capture = 1'b1;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            if (stat.coord_err || !(stat.op inside {OP_LOAD, OP_STEP, OP_READ})) begin
               cmd.rsp_sel = RSEL_ZERO;
               if (rsp_free) begin
                  cmd.rsp_load = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (stat.op == OP_LOAD) begin
               // rewrite while stalled is harmless
               cmd.ram_en    = 1'b1;
               cmd.ram_we    = 1'b1;
               cmd.addr_sel  = ASEL_CENTER;
               cmd.wdata_sel = WSEL_VALUE;
               cmd.rsp_sel   = RSEL_ZERO;
               if (rsp_free) begin
                  cmd.rsp_load = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.ram_en   = 1'b1;
               cmd.addr_sel = ASEL_CENTER;
               state_in = S_CAP;
            end
         end
         S_CAP: begin
            cmd.label_capture = 1'b1;
            if (stat.op == OP_READ) begin
               cmd.rsp_sel = RSEL_RDATA;
               if (rsp_free) begin
                  cmd.rsp_load = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.ram_en    = 1'b1;
               cmd.ram_we    = 1'b1;
               cmd.addr_sel  = ASEL_UP;
               cmd.wdata_sel = WSEL_RDATA;
               state_in = S_W1;
            end
         end
         S_W1: begin
            cmd.ram_en    = 1'b1;
            cmd.ram_we    = 1'b1;
            cmd.addr_sel  = ASEL_DOWN;
            cmd.wdata_sel = WSEL_LABEL;
            state_in = S_W2;
         end
         S_W2: begin
            cmd.ram_en    = 1'b1;
            cmd.ram_we    = 1'b1;
            cmd.addr_sel  = ASEL_LEFT;
            cmd.wdata_sel = WSEL_LABEL;
            state_in = S_W3;
         end
         S_W3: begin
            cmd.ram_en    = 1'b1;
            cmd.ram_we    = 1'b1;
            cmd.addr_sel  = ASEL_RIGHT;
            cmd.wdata_sel = WSEL_LABEL;
            cmd.rsp_sel   = RSEL_LABEL;
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/toroidal_grid_spread_step_top.sv =====
// Top level of the toroidal grid spread step block.
// After accept, a load or error responds from issue, a read from capture, a step from its last write.
// One request is in work at a time, each bounded
// by the single grid RAM port (one read plus four neighbor writes per step).
// A waiting response sits in its own register, so the next request is taken meanwhile.
// Synchronous reset clears the controller, response valid and sizes (64 x 64);
// no request is taken during reset; grid contents are not cleared and must be loaded.
module toroidal_grid_spread_step_top #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64,
   parameter int LABEL_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  tgss_pkg::tgss_req_type         req_data,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output tgss_pkg::tgss_rsp_type         rsp_data,
   // configuration writes
   input  logic                           csr_write_en,
   input  logic [tgss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tgss_pkg::CSR_W-1:0]     csr_wdata
);
   import tgss_pkg::*;

   tgss_cmd_type  cmd;
   tgss_stat_type stat;

   // Controller: one state per grid access, holds the final state
   // until the response register is free.
   tgss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: request hold, wrap-around neighbor addresses,
   // grid RAM (row * MAX_COLS + col) and response payload.
   tgss_datapath #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .LABEL_BITS (LABEL_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_data     (req_data),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_data     (rsp_data)
   );

endmodule

// ===== sv/tgss_checker.sv =====
// Port-level checks for the toroidal grid spread step block, bound to the top level.
module tgss_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input tgss_pkg::tgss_req_type         req_data,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input tgss_pkg::tgss_rsp_type         rsp_data,
   input logic                           csr_write_en,
   input logic [tgss_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [tgss_pkg::CSR_W-1:0]     csr_wdata
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one request in work at a time
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.coord_error |-> rsp_data.cell_value == 8'd0)
      else $error("coordinate error with nonzero label");

endmodule

bind toroidal_grid_spread_step_top tgss_checker u_tgss_checker (.*);
